@@ rtl/fod_pkg.sv @@
`default_nettype none

package fod_pkg;

  // ring geometry
  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // register field widths
  localparam int LEN_W      = 7;
  localparam int START_W    = 6;
  localparam int AXES       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // wide enough for the effective length and for index + 1
  localparam int CNT_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

  localparam int COORD_W = 32;

  // output queue
  localparam int OUT_DEPTH = 3;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef coord_t [AXES-1:0]  vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HISTORY_ON  = 3'd0,
    CFG_RING_LENGTH = 3'd1,
    CFG_WRITE_START = 3'd2,
    CFG_UPDATE_MASK = 3'd3,
    CFG_OFFSET_MASK = 3'd4
  } cfg_reg_t;

  // controller -> all lanes
  typedef struct packed {
    logic            load;
    logic            frame;
    logic            wr_en;
    idx_t            wr_idx;
    idx_t            rd_idx;
    logic            ring_vld;
    logic [AXES-1:0] keep;
    logic [AXES-1:0] ring_sel;
  } ring_ctl_t;

  // controller -> one lane
  typedef struct packed {
    logic load;
    logic frame;
    logic keep;
    logic wr_en;
    idx_t wr_idx;
    idx_t rd_idx;
    logic ring_sel;
    logic ring_vld;
  } lane_ctl_t;

  // zero reads as one, oversize saturates to the ring depth
  function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [CNT_W-1:0] ext;
    ext = CNT_W'(len);
    if (ext == '0) return CNT_W'(1);
    if (ext > CNT_W'(RING_DEPTH)) return CNT_W'(RING_DEPTH);
    return ext;
  endfunction

  function automatic logic [CNT_W-1:0] eff_start(input logic [START_W-1:0] ws,
                                                  input logic [CNT_W-1:0]   len);
    logic [CNT_W-1:0] ext;
    ext = CNT_W'(ws);
    return (ext < len) ? ext : len - CNT_W'(1);
  endfunction

  function automatic idx_t next_idx(input idx_t idx, input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] n;
    n = CNT_W'(idx) + CNT_W'(1);
    return (n >= len) ? '0 : n[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/fod_ctrl.sv @@
`default_nettype none

module fod_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_fire,
  input  wire logic                          in_command,
  input  wire logic                          cfg_we,
  input  wire logic [fod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fod_pkg::CFG_DATA_W-1:0] cfg_data,
  output fod_pkg::ring_ctl_t                 ring_ctl
);
  import fod_pkg::*;

  logic                  hist_r, hist_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [START_W-1:0]    ws_r, ws_nxt;
  logic [AXES-1:0]       upd_r, upd_nxt;
  logic [AXES-1:0]       omask_r, omask_nxt;
  idx_t                  rd_idx_r, rd_idx_nxt;
  idx_t                  wr_idx_r, wr_idx_nxt;
  logic                  primed_r, primed_nxt;
  logic [RING_DEPTH-1:0] valid_r, valid_nxt;

  logic             cfg_hit;
  logic             hist_frame;
  logic [CNT_W-1:0] len_eff;
  logic [CNT_W-1:0] start_eff;

  assign hist_frame = in_fire & in_command & hist_r;

  always_comb begin
    hist_nxt  = hist_r;
    len_nxt   = len_r;
    ws_nxt    = ws_r;
    upd_nxt   = upd_r;
    omask_nxt = omask_r;
    cfg_hit   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HISTORY_ON: begin
          hist_nxt = cfg_data[0];
          cfg_hit  = 1'b1;
        end
        CFG_RING_LENGTH: begin
          len_nxt = cfg_data[LEN_W-1:0];
          cfg_hit = 1'b1;
        end
        CFG_WRITE_START: begin
          ws_nxt  = cfg_data[START_W-1:0];
          cfg_hit = 1'b1;
        end
        CFG_UPDATE_MASK: begin
          upd_nxt = cfg_data[AXES-1:0];
          cfg_hit = 1'b1;
        end
        CFG_OFFSET_MASK: begin
          omask_nxt = cfg_data[AXES-1:0];
          cfg_hit   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // without a write the _nxt values equal the stored ones
  assign len_eff   = eff_len(len_nxt);
  assign start_eff = eff_start(ws_nxt, len_eff);

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    primed_nxt = primed_r;
    valid_nxt  = valid_r;
    if (cfg_hit) begin
      rd_idx_nxt = '0;
      wr_idx_nxt = start_eff[IDX_W-1:0];
      primed_nxt = 1'b0;
      valid_nxt  = '0;
    end else if (hist_frame) begin
      rd_idx_nxt          = next_idx(rd_idx_r, len_eff);
      wr_idx_nxt          = next_idx(wr_idx_r, len_eff);
      valid_nxt[wr_idx_r] = 1'b1;
      if (!primed_r && (CNT_W'(rd_idx_r) == start_eff)) begin
        primed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= 1'b0;
      len_r    <= LEN_W'(1);
      ws_r     <= '0;
      upd_r    <= '0;
      omask_r  <= '1;
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      primed_r <= 1'b0;
      valid_r  <= '0;
    end else begin
      hist_r   <= hist_nxt;
      len_r    <= len_nxt;
      ws_r     <= ws_nxt;
      upd_r    <= upd_nxt;
      omask_r  <= omask_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      primed_r <= primed_nxt;
      valid_r  <= valid_nxt;
    end
  end

  assign ring_ctl.load     = in_fire;
  assign ring_ctl.frame    = in_command;
  assign ring_ctl.wr_en    = hist_frame;
  assign ring_ctl.wr_idx   = wr_idx_r;
  assign ring_ctl.rd_idx   = rd_idx_r;
  assign ring_ctl.ring_vld = valid_r[rd_idx_r];
  assign ring_ctl.keep     = omask_r;
  assign ring_ctl.ring_sel = {AXES{hist_r & primed_r & in_command}} & upd_r;

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (rd_idx_r == '0) && !primed_r && (valid_r == '0))
    else $error("ring state not cleared after register write");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(rd_idx_r) < eff_len(len_r))
    else $error("read index beyond ring length");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(wr_idx_r) < eff_len(len_r))
    else $error("write index beyond ring length");

  a_prime_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(primed_r) |-> $past(hist_frame))
    else $error("primed set without a history frame");

endmodule

`default_nettype wire

@@ rtl/fod_lane.sv @@
`default_nettype none

module fod_lane (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  fod_pkg::lane_ctl_t ctl,
  input  fod_pkg::coord_t    target,
  output fod_pkg::coord_t    result
);
  import fod_pkg::*;

  coord_t last_r;
  coord_t diff_now;
  coord_t diff_q_r;
  coord_t ring_q_r;
  logic   sel_q_r;
  logic   vld_q_r;
  coord_t ring_mem [RING_DEPTH];

  // modulo 2^32 difference, zero for reference loads and masked axes
  assign diff_now = (ctl.frame && ctl.keep) ? target - last_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      sel_q_r <= 1'b0;
      vld_q_r <= 1'b0;
    end else if (ctl.load) begin
      last_r  <= target;
      sel_q_r <= ctl.ring_sel;
      vld_q_r <= ctl.ring_vld;
    end
  end

  // read-first: same-cycle write to the read slot returns the old entry
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ring_mem[ctl.wr_idx] <= diff_now;
    end
    if (ctl.load) begin
      ring_q_r <= ring_mem[ctl.rd_idx];
      diff_q_r <= diff_now;
    end
  end

  // unwritten entries read as zero
  assign result = sel_q_r ? (vld_q_r ? ring_q_r : '0) : diff_q_r;

endmodule

`default_nettype wire

@@ rtl/fod_merge.sv @@
`default_nettype none

module fod_merge (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  fod_pkg::vec_t   lane_res,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output fod_pkg::vec_t   out_vec
);
  import fod_pkg::*;

  logic             b_v_r;
  vec_t             fifo_r [OUT_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [OCC_W-1:0] cnt_r, cnt_nxt;
  logic [OCC_W:0]   occ;
  logic             push;
  logic             pop;

  assign push      = b_v_r;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign out_vec   = fifo_r[rptr_r];

  // requests in the lane stage count against queue space
  assign occ      = (OCC_W + 1)'(cnt_r) + (OCC_W + 1)'(b_v_r);
  assign in_ready = (occ < (OCC_W + 1)'(OUT_DEPTH));

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + OCC_W'(1);
      2'b01:   cnt_nxt = cnt_r - OCC_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r  <= 1'b0;
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      b_v_r  <= load;
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= lane_res;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < OCC_W'(OUT_DEPTH)))
    else $error("result pushed into full queue");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= (OCC_W + 1)'(OUT_DEPTH))
    else $error("in-flight requests exceed queue depth");

  a_load_credit: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> in_ready)
    else $error("request loaded without queue credit");

endmodule

`default_nettype wire

@@ rtl/follow_offset_delay_line.sv @@
`default_nettype none

// Camera follow offset with an optional delay ring. Each request carries a
// command and a target position (x, y, z, signed 20.12). A set-reference
// request (command 0) loads the last target and returns a zero offset; a frame
// request (command 1) returns target minus last target per axis, wrapping mod
// 2^32, with axes outside offset_mask forced to zero. With history_on set the
// difference is also written into a 64-entry ring; once the read index has
// reached the (clamped) write_start, axes in update_mask return the ring entry
// at the read index instead, i.e. the difference from a fixed number of frames
// earlier. Any register write clears the ring and the read index and sets the
// write index to the clamped write_start; the last target is kept. Registers
// may be written only while no request is in flight. Timing: one request per
// clock sustained while the output queue has room; each result is registered
// in its lane (ring read), then in the output queue. Each axis lane's ring takes
// one read and one write per frame; a 3-entry output queue lets in_ready stay
// high while results wait for out_ready, until it fills. Ring clearing is done
// through per-entry valid bits, so there is no clearing pass after reset.
module follow_offset_delay_line (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_command,
  input  wire logic signed [31:0]            in_target_x,
  input  wire logic signed [31:0]            in_target_y,
  input  wire logic signed [31:0]            in_target_z,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [31:0]                 out_offset_x,
  output logic signed [31:0]                 out_offset_y,
  output logic signed [31:0]                 out_offset_z,

  input  wire logic                          cfg_we,
  input  wire logic [fod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fod_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fod_pkg::*;

  logic      in_fire;
  ring_ctl_t ring_ctl;
  vec_t      targets;
  vec_t      lane_res;
  vec_t      out_vec;

  assign in_fire = in_valid & in_ready;

  // lane 0 is x, 1 is y, 2 is z (matches mask bit order)
  assign targets[0] = $unsigned(in_target_x);
  assign targets[1] = $unsigned(in_target_y);
  assign targets[2] = $unsigned(in_target_z);

  // indices, priming, valid bits and register file
  fod_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_command (in_command),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ring_ctl   (ring_ctl)
  );

  // one subtract / ring lane per axis, all sharing the same indices
  for (genvar g = 0; g < AXES; g++) begin : g_lane
    lane_ctl_t lctl;

    assign lctl.load     = ring_ctl.load;
    assign lctl.frame    = ring_ctl.frame;
    assign lctl.keep     = ring_ctl.keep[g];
    assign lctl.wr_en    = ring_ctl.wr_en;
    assign lctl.wr_idx   = ring_ctl.wr_idx;
    assign lctl.rd_idx   = ring_ctl.rd_idx;
    assign lctl.ring_sel = ring_ctl.ring_sel[g];
    assign lctl.ring_vld = ring_ctl.ring_vld;

    fod_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lctl),
      .target (targets[g]),
      .result (lane_res[g])
    );
  end

  // gathers the three lane results into one output queue
  fod_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .lane_res  (lane_res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_vec   (out_vec)
  );

  assign out_offset_x = $signed(out_vec[0]);
  assign out_offset_y = $signed(out_vec[1]);
  assign out_offset_z = $signed(out_vec[2]);

endmodule

`default_nettype wire
